[src/bpsm_pkg.sv]
// shared types, constants and register map of the bitcrush pitch shift mixer
package bpsm_pkg;

  // default sizes handed to the top level parameters
  localparam int DELAY_DEPTH_DEF  = 1024;
  localparam int SINE_ENTRIES_DEF = 1024;
  localparam int FRAC_BITS_DEF    = 16;

  // configuration port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CRUSH_FACTOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FM_DEPTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_ANALOG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LFO_STEP     = 3'd4;

  // register values after reset
  localparam logic [4:0]  CRUSH_FACTOR_RST = 5'd1;
  localparam logic [15:0] PITCH_SPEED_RST  = 16'd16384;
  localparam logic [13:0] FM_DEPTH_RST     = 14'd0;
  localparam logic        USE_ANALOG_RST   = 1'b1;
  localparam logic [23:0] LFO_STEP_RST     = 24'd973916;

  // read step limits, Q2.14 (0.2 and 2.5)
  localparam logic signed [17:0] STEP_MIN = 18'sd3277;
  localparam logic signed [17:0] STEP_MAX = 18'sd40960;

  // input beat
  typedef struct packed {
    logic        [11:0] analog_sample;
    logic signed [15:0] digital_sample;
    logic signed [11:0] extra_voice;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [11:0] dac_value;
  } out_item_t;

  // configuration write beat
  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_beat_t;

  // controller to datapath commands
  typedef struct packed {
    logic in_ready;
    logic write;
    logic sine;
    logic square;
    logic cube;
    logic fm;
    logic step;
    logic read_a;
    logic read_b;
    logic interp;
    logic mix;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } dp_status_t;

endpackage

[src/bpsm_stream_if.sv]
// valid/ready channel carrying one payload beat
interface bpsm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[src/bpsm_ctrl.sv]
// sequencing state machine for one audio tick
module bpsm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bpsm_pkg::dp_status_t status,
  output bpsm_pkg::dp_cmd_t    cmd
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_WRITE  = 11'b000_0000_0010,
    ST_SINE   = 11'b000_0000_0100,
    ST_SQUARE = 11'b000_0000_1000,
    ST_CUBE   = 11'b000_0001_0000,
    ST_FM     = 11'b000_0010_0000,
    ST_STEP   = 11'b000_0100_0000,
    ST_READ_A = 11'b000_1000_0000,
    ST_READ_B = 11'b001_0000_0000,
    ST_INTERP = 11'b010_0000_0000,
    ST_MIX    = 11'b100_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (status.in_valid) state_nxt = ST_WRITE;
      ST_WRITE:  state_nxt = ST_SINE;
      ST_SINE:   state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_CUBE;
      ST_CUBE:   state_nxt = ST_FM;
      ST_FM:     state_nxt = ST_STEP;
      ST_STEP:   state_nxt = ST_READ_A;
      ST_READ_A: state_nxt = ST_READ_B;
      ST_READ_B: state_nxt = ST_INTERP;
      ST_INTERP: state_nxt = ST_MIX;
      ST_MIX:    if (status.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands decoded from the state
  always_comb begin
    cmd          = '0;
    cmd.in_ready = (state_r == ST_IDLE);
    cmd.write    = (state_r == ST_WRITE);
    cmd.sine     = (state_r == ST_SINE);
    cmd.square   = (state_r == ST_SQUARE);
    cmd.cube     = (state_r == ST_CUBE);
    cmd.fm       = (state_r == ST_FM);
    cmd.step     = (state_r == ST_STEP);
    cmd.read_a   = (state_r == ST_READ_A);
    cmd.read_b   = (state_r == ST_READ_B);
    cmd.interp   = (state_r == ST_INTERP);
    cmd.mix      = (state_r == ST_MIX) && status.out_free;
  end

endmodule

[src/bpsm_dp.sv]
// datapath: registers, bitcrusher, lfo, delay store, interpolation and mix
module bpsm_dp #(
  parameter int DELAY_DEPTH  = bpsm_pkg::DELAY_DEPTH_DEF,
  parameter int SINE_ENTRIES = bpsm_pkg::SINE_ENTRIES_DEF,
  parameter int FRAC_BITS    = bpsm_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bpsm_pkg::dp_cmd_t    cmd,
  output bpsm_pkg::dp_status_t status,
  bpsm_stream_if.sink          in_if,
  bpsm_stream_if.source        out_if,
  bpsm_stream_if.sink          cfg_if
);

  localparam int AW   = $clog2(DELAY_DEPTH);
  localparam int PW   = AW + FRAC_BITS;
  localparam int SW   = $clog2(SINE_ENTRIES);
  localparam int DW   = FRAC_BITS + 14;
  localparam int SH_L = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
  localparam int SH_R = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
  localparam logic [PW:0]   LIMIT     = (PW+1)'(DELAY_DEPTH) << FRAC_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
  localparam logic [63:0]   Q30_ONE   = 64'd1073741824;

  typedef logic signed [15:0] sine_rom_t [SINE_ENTRIES];

  // sin(pi/2 * t), t and result in unsigned Q30, truncating products
  function automatic logic [63:0] quarter_wave(input logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] p;
    t2 = (t * t) >> 30;
    p  = 64'd5026996 - ((t2 * 64'd172273) >> 30);
    p  = 64'd85569305 - ((t2 * p) >> 30);
    p  = 64'd693598668 - ((t2 * p) >> 30);
    p  = 64'd1686629713 - ((t2 * p) >> 30);
    return (t * p) >> 30;
  endfunction

  // full sine table in Q1.15, built at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] q4;
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] mag;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      q4   = 64'(i) * 64'd4;
      quad = q4 / SINE_ENTRIES;
      r    = q4 - quad * SINE_ENTRIES;
      t    = (r << 30) / SINE_ENTRIES;
      if (quad[0]) t = Q30_ONE - t;
      mag = (quarter_wave(t) + 64'd16384) >> 15;
      if (mag > 64'd32767) mag = 64'd32767;
      rom[i] = quad[1] ? -16'(mag) : 16'(mag);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // configuration registers
  logic [4:0]  crush_r;
  logic [15:0] pitch_r;
  logic [13:0] depth_r;
  logic        use_analog_r;
  logic [23:0] lfo_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crush_r      <= bpsm_pkg::CRUSH_FACTOR_RST;
      pitch_r      <= bpsm_pkg::PITCH_SPEED_RST;
      depth_r      <= bpsm_pkg::FM_DEPTH_RST;
      use_analog_r <= bpsm_pkg::USE_ANALOG_RST;
      lfo_step_r   <= bpsm_pkg::LFO_STEP_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.payload.index)
        bpsm_pkg::REG_CRUSH_FACTOR: crush_r      <= cfg_if.payload.data[4:0];
        bpsm_pkg::REG_PITCH_SPEED:  pitch_r      <= cfg_if.payload.data[15:0];
        bpsm_pkg::REG_FM_DEPTH:     depth_r      <= cfg_if.payload.data[13:0];
        bpsm_pkg::REG_USE_ANALOG:   use_analog_r <= cfg_if.payload.data[0];
        bpsm_pkg::REG_LFO_STEP:     lfo_step_r   <= cfg_if.payload.data[23:0];
        default: ;
      endcase
    end
  end

  assign cfg_if.ready = 1'b1;

  // handshake and status
  logic take;
  logic out_valid_r;

  assign in_if.ready     = cmd.in_ready;
  assign take            = in_if.valid && cmd.in_ready;
  assign status.in_valid = in_if.valid;
  assign status.out_free = !out_valid_r || out_if.ready;

  // source select and bitcrusher
  logic [11:0] src_sample;
  logic [4:0]  hold_inc;
  logic [4:0]  hold_r;
  logic [11:0] held_r;
  logic [11:0] extra_r;
  logic [31:0] phase_r;

  assign src_sample = use_analog_r ? in_if.payload.analog_sample
                                   : {~in_if.payload.digital_sample[15],
                                      in_if.payload.digital_sample[14:4]};
  assign hold_inc   = hold_r + 5'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= '0;
      held_r  <= '0;
      phase_r <= '0;
    end else if (take) begin
      if (hold_inc >= crush_r) begin
        hold_r <= '0;
        held_r <= src_sample;
      end else begin
        hold_r <= hold_inc;
      end
      phase_r <= phase_r + {8'd0, lfo_step_r};
    end
  end

  always_ff @(posedge clk) begin
    if (take) extra_r <= in_if.payload.extra_voice;
  end

  // lfo table index, sine, square, cube and depth product
  logic [32+SW:0]     idx_prod;
  logic [SW-1:0]      idx_r;
  logic signed [15:0] sine_r;
  logic               sine_neg;
  logic [14:0]        sine_mag;
  logic [29:0]        sq_nxt;
  logic [29:0]        sq_r;
  logic [14:0]        mag_r;
  logic               neg_r;
  logic [44:0]        cube_prod;
  logic [14:0]        cube_r;
  logic [28:0]        fm_prod;
  logic [13:0]        fm_r;

  assign idx_prod  = (33+SW)'(phase_r) * (33+SW)'(SINE_ENTRIES);
  assign sine_neg  = sine_r[15];
  assign sine_mag  = sine_neg ? 15'(-sine_r) : sine_r[14:0];
  assign sq_nxt    = 30'(sine_mag) * 30'(sine_mag);
  assign cube_prod = 45'(sq_r) * 45'(mag_r);
  assign fm_prod   = 29'(cube_r) * 29'(depth_r);

  always_ff @(posedge clk) begin
    if (cmd.write)  idx_r  <= idx_prod[32 +: SW];
    if (cmd.sine)   sine_r <= SINE_ROM[idx_r];
    if (cmd.square) begin
      sq_r  <= sq_nxt;
      mag_r <= sine_mag;
      neg_r <= sine_neg;
    end
    if (cmd.cube)   cube_r <= cube_prod[44:30];
    if (cmd.fm)     fm_r   <= fm_prod[28:15];
  end

  // read step, clamped, and read pointer advance
  logic signed [17:0] step_raw;
  logic [15:0]        step_cl;
  logic [PW+16:0]     step_ext;
  logic [PW:0]        adv;
  logic [PW:0]        rp_sum;
  logic [PW:0]        rp_nxt;
  logic [PW-1:0]      rp_r;

  assign step_raw = neg_r ? $signed({2'b00, pitch_r}) - $signed({4'b0000, fm_r})
                          : $signed({2'b00, pitch_r}) + $signed({4'b0000, fm_r});

  always_comb begin
    if (step_raw < bpsm_pkg::STEP_MIN) begin
      step_cl = 16'(bpsm_pkg::STEP_MIN);
    end else if (step_raw > bpsm_pkg::STEP_MAX) begin
      step_cl = 16'(bpsm_pkg::STEP_MAX);
    end else begin
      step_cl = step_raw[15:0];
    end
  end

  assign step_ext = (PW+17)'(step_cl);
  assign adv      = (PW+1)'((step_ext << SH_L) >> SH_R);
  assign rp_sum   = {1'b0, rp_r} + adv;
  assign rp_nxt   = (rp_sum >= LIMIT) ? rp_sum - LIMIT : rp_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= '0;
    end else if (cmd.step) begin
      rp_r <= rp_nxt[PW-1:0];
    end
  end

  // delay store: one write and two reads per tick through a single port
  logic [11:0]          store_mem [DELAY_DEPTH];
  logic [AW-1:0]        wp_r;
  logic                 full_r;
  logic [AW-1:0]        i0;
  logic [AW-1:0]        i1;
  logic [AW-1:0]        rd_addr;
  logic [11:0]          rd_q_r;
  logic                 rd_ok_r;
  logic [11:0]          rd_val;

  assign i0      = rp_r[PW-1:FRAC_BITS];
  assign i1      = (i0 == LAST_ADDR) ? '0 : i0 + 1'b1;
  assign rd_addr = cmd.read_b ? i1 : i0;
  // entries never written read as zero
  assign rd_val  = rd_ok_r ? rd_q_r : 12'd0;

  always_ff @(posedge clk) begin
    if (cmd.write) store_mem[wp_r] <= held_r;
    if (cmd.read_a || cmd.read_b) rd_q_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      full_r  <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      if (cmd.write) begin
        wp_r <= (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;
        if (wp_r == LAST_ADDR) full_r <= 1'b1;
      end
      if (cmd.read_a || cmd.read_b) rd_ok_r <= full_r || (rd_addr < wp_r);
    end
  end

  // linear interpolation, re-centred around midscale
  logic [11:0]            a_r;
  logic signed [12:0]     diff;
  logic signed [12:0]     a_c;
  logic signed [DW-1:0]   prod;
  logic signed [DW-1:0]   base;
  logic signed [DW-1:0]   d_r;

  assign diff = $signed({1'b0, rd_val}) - $signed({1'b0, a_r});
  assign a_c  = $signed({1'b0, a_r}) - 13'sd2048;
  assign prod = DW'(diff) * DW'($signed({1'b0, rp_r[FRAC_BITS-1:0]}));
  assign base = DW'(a_c) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (cmd.read_b) a_r <= rd_val;
    if (cmd.interp) d_r <= base + prod;
  end

  // truncate toward zero, add the extra voice, clamp to 12 bits
  logic                 d_neg;
  logic [DW-1:0]        d_mag;
  logic [DW-1:0]        d_abs;
  logic signed [12:0]   live;
  logic signed [13:0]   mixed;
  logic [11:0]          mix_cl;
  logic [11:0]          dac_r;

  assign d_neg = d_r[DW-1];
  assign d_mag = d_neg ? DW'(-d_r) : DW'(d_r);
  assign d_abs = d_mag >> FRAC_BITS;
  assign live  = d_neg ? -$signed(13'(d_abs)) : $signed(13'(d_abs));
  assign mixed = 14'(live) + 14'($signed(extra_r)) + 14'sd2048;

  always_comb begin
    if (mixed < 14'sd0) begin
      mix_cl = 12'd0;
    end else if (mixed > 14'sd4095) begin
      mix_cl = 12'd4095;
    end else begin
      mix_cl = mixed[11:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.mix) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix) dac_r <= mix_cl;
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.payload.dac_value = dac_r;

endmodule

[src/bitcrush_pitch_shift_mixer_top.sv]
// top level of the bitcrush pitch shift mixer: controller plus datapath
// a taken beat steps the write, sine, square, cube, fm, step, read_a, read_b, interp and mix
// states; the next beat waits for idle, set by the one-port store and the multiply chain
// a finished result waits in the output register while the next beat is taken
// reset: synchronous rst_n restores register defaults and clears pointers, lfo and
//   hold state; the store is not swept, entries not yet written read as zero
module bitcrush_pitch_shift_mixer_top #(
  parameter int DELAY_DEPTH  = bpsm_pkg::DELAY_DEPTH_DEF,
  parameter int SINE_ENTRIES = bpsm_pkg::SINE_ENTRIES_DEF,
  parameter int FRAC_BITS    = bpsm_pkg::FRAC_BITS_DEF
) (
  input logic           clk,
  input logic           rst_n,
  bpsm_stream_if.sink   in_if,
  bpsm_stream_if.source out_if,
  bpsm_stream_if.sink   cfg_if
);

  bpsm_pkg::dp_cmd_t    cmd;
  bpsm_pkg::dp_status_t status;

  // sequencer
  bpsm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  // arithmetic and storage
  bpsm_dp #(
    .DELAY_DEPTH  (DELAY_DEPTH),
    .SINE_ENTRIES (SINE_ENTRIES),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .status (status),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

endmodule
